### src/vdi_pkg.sv
// Package for the vertex deduplication indexer.
// Holds table sizing constants, the sequencer state type and the vdi_scan port structs.
// No dependencies.
`default_nettype none

package vdi_pkg;

  // Table sizing.
  localparam int TABLE_DEPTH = 256;
  localparam int INDEX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = INDEX_W + 1;

  // Key and result field widths.
  localparam int WORD_W    = 32;
  localparam int KEY_WORDS = 8;
  localparam int KEY_W     = WORD_W * KEY_WORDS;
  localparam int IDX_OUT_W = 8;

  // Codes of the kind field.
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } scan_state_t;

  // One result beat.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 is_new;
    logic                 table_full;
  } result_t;

  // Table memory access requests from the sequencer.
  typedef struct packed {
    logic               rd_en;
    logic [INDEX_W-1:0] rd_addr;
    logic               wr_en;
    logic [INDEX_W-1:0] wr_addr;
  } ram_req_t;

  // Low bits of a table index as carried in the result field.
  function automatic logic [IDX_OUT_W-1:0] out_index(input logic [INDEX_W-1:0] idx);
    logic [INDEX_W+IDX_OUT_W-1:0] wide;
    wide = {{IDX_OUT_W{1'b0}}, idx};
    return wide[IDX_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/vdi_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module vdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/vdi_scan.sv
// Vertex deduplication scan sequencer: walks the stored entries one per cycle through
// the shared key comparator, then appends on a miss unless full. Uses vdi_pkg.
`default_nettype none

module vdi_scan (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 start_kind,
  input  wire logic [vdi_pkg::KEY_W-1:0] key,
  input  wire logic [vdi_pkg::KEY_W-1:0] rd_data,
  input  wire logic                 done_ready,
  output vdi_pkg::ram_req_t         ram_req,
  output logic                      busy,
  output logic                      done,
  output vdi_pkg::result_t          result
);

  import vdi_pkg::*;

  scan_state_t        state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [COUNT_W-1:0] rd_idx, rd_idx_next;
  logic               cmp_valid, cmp_valid_next;
  logic [INDEX_W-1:0] cmp_idx, cmp_idx_next;
  result_t            result_next;

  logic match;
  logic hit;
  logic more;
  logic full;

  // Shared comparator and scan conditions.
  assign match = (rd_data == key);
  assign hit   = cmp_valid && match;
  assign more  = (rd_idx < count);
  assign full  = (count == COUNT_W'(TABLE_DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (start_kind == KIND_CLEAR) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || !more) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (done_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory requests, busy and done.
  always_comb begin
    ram_req         = '0;
    ram_req.rd_addr = rd_idx[INDEX_W-1:0];
    ram_req.wr_addr = count[INDEX_W-1:0];
    busy            = 1'b1;
    done            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        ram_req.rd_en = !hit && more;
        ram_req.wr_en = !hit && !more && !full;
      end
      ST_FINISH: begin
        done = done_ready;
      end
      default: busy = 1'b1;
    endcase
  end

  // Datapath next values: counters, compare tag and result.
  always_comb begin
    count_next     = count;
    rd_idx_next    = rd_idx;
    cmp_valid_next = cmp_valid;
    cmp_idx_next   = cmp_idx;
    result_next    = result;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (start_kind == KIND_CLEAR) begin
            count_next  = '0;
            result_next = '0;
          end else begin
            rd_idx_next    = '0;
            cmp_valid_next = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          result_next             = '0;
          result_next.entry_index = out_index(cmp_idx);
        end else if (more) begin
          cmp_valid_next = 1'b1;
          cmp_idx_next   = rd_idx[INDEX_W-1:0];
          rd_idx_next    = rd_idx + COUNT_W'(1);
        end else if (full) begin
          result_next            = '0;
          result_next.table_full = 1'b1;
        end else begin
          result_next             = '0;
          result_next.entry_index = out_index(count[INDEX_W-1:0]);
          result_next.is_new      = 1'b1;
          count_next              = count + COUNT_W'(1);
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    cmp_idx <= cmp_idx_next;
    result  <= result_next;
  end

endmodule

`default_nettype wire

### src/vertex_dedup_indexer_core.sv
// Top level of the vertex deduplication indexer.
// Instantiates the scan sequencer (vdi_scan) and the vertex table (vdi_ram); uses vdi_pkg.
`default_nettype none

// Looks up a vertex of eight raw 32-bit words in a table of unique vertices by exact bit
// match and returns its index, or appends it as a new entry and flags it new; a miss on a
// full table reports table_full and stores nothing, and a clear beat empties the table.
// The block takes one beat at a time: in_stall is high from the cycle after a beat is
// accepted until its result moves into the output register, which then waits for the
// consumer on its own. A clear goes straight to the result; a vertex is compared with
// the stored entries in order until a hit or the last one; that scan is set by the single
// read port of the table memory, which feeds one stored entry per cycle to the one 256-bit
// key comparator. No clearing pass follows reset: only entries below the entry count are
// ever compared.
module vertex_dedup_indexer_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       kind,
  input  wire logic [vdi_pkg::WORD_W-1:0] pos_x,
  input  wire logic [vdi_pkg::WORD_W-1:0] pos_y,
  input  wire logic [vdi_pkg::WORD_W-1:0] pos_z,
  input  wire logic [vdi_pkg::WORD_W-1:0] tex_u,
  input  wire logic [vdi_pkg::WORD_W-1:0] tex_v,
  input  wire logic [vdi_pkg::WORD_W-1:0] norm_x,
  input  wire logic [vdi_pkg::WORD_W-1:0] norm_y,
  input  wire logic [vdi_pkg::WORD_W-1:0] norm_z,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [vdi_pkg::IDX_OUT_W-1:0]   entry_index,
  output logic                            is_new,
  output logic                            table_full
);

  import vdi_pkg::*;

  logic             accept;
  logic             busy;
  logic             done;
  logic             done_ready;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] rd_data;
  ram_req_t         ram_req;
  result_t          result;
  logic             out_valid_next;

  assign in_stall   = busy;
  assign accept     = in_valid && !in_stall;
  assign done_ready = !out_valid || !out_stall;

  // Capture the key of an accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= {norm_z, norm_y, norm_x, tex_v, tex_u, pos_z, pos_y, pos_x};
    end
  end

  // Scan sequencer with the shared comparator.
  vdi_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .start_kind (kind),
    .key        (key),
    .rd_data    (rd_data),
    .done_ready (done_ready),
    .ram_req    (ram_req),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

  // Table of unique vertex keys.
  vdi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (key),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  // Output register: loads a finished result, holds it while stalled.
  always_comb begin
    out_valid_next = out_valid;
    if (done) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      entry_index <= result.entry_index;
      is_new      <= result.is_new;
      table_full  <= result.table_full;
    end
  end

  // An accepted beat holds off the next one: in_stall is high in the cycle after it.
  assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("input accepted on the cycle after a beat was taken");

  // A new entry is never reported together with a full table.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(is_new && table_full))
    else $error("result flags both a new entry and a full table");

  // A full-table result carries index zero.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && table_full) |-> (entry_index == '0))
    else $error("full-table result with a nonzero index");

  // A result is only loaded while the output register is free or draining.
  assert property (@(posedge clk) disable iff (rst) done |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled output beat");

endmodule

`default_nettype wire

### verif/vertex_dedup_indexer_core_tb.sv
// Self-checking testbench for the vertex deduplication indexer top level.
// Depends on vdi_pkg and vertex_dedup_indexer_core; predicts each result from its own
// copy of the unique vertex table and checks every output beat in order.
module vertex_dedup_indexer_core_tb;
  import vdi_pkg::*;

  typedef logic [KEY_W-1:0] vertex_key_t;

  localparam int IDX_W        = IDX_OUT_W;
  localparam int ITEM_BUDGET  = 1500;
  localparam int CYCLE_LIMIT  = ITEM_BUDGET * (TABLE_DEPTH + 64) * 4 + 1000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int MESH_ITEMS   = 195;
  localparam int FULL_PROBES  = 24;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              kind;
  logic [WORD_W-1:0] pos_x;
  logic [WORD_W-1:0] pos_y;
  logic [WORD_W-1:0] pos_z;
  logic [WORD_W-1:0] tex_u;
  logic [WORD_W-1:0] tex_v;
  logic [WORD_W-1:0] norm_x;
  logic [WORD_W-1:0] norm_y;
  logic [WORD_W-1:0] norm_z;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  entry_index;
  logic              is_new;
  logic              table_full;

  // Our own copy of the unique vertex table and the results still owed by the block.
  vertex_key_t unique_keys [TABLE_DEPTH];
  int unsigned unique_count = 0;
  result_t     lookup_results [$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned error_count        = 0;
  int unsigned cycle_count        = 0;

  vertex_dedup_indexer_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .norm_x      (norm_x),
    .norm_y      (norm_y),
    .norm_z      (norm_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_index (entry_index),
    .is_new      (is_new),
    .table_full  (table_full)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Search the table bit for bit; on a miss append at the next index unless it is full.
  function automatic result_t lookup_or_insert(logic kind_bit, vertex_key_t key);
    result_t r;
    r = '0;
    if (kind_bit == KIND_CLEAR) begin
      unique_count = 0;
      return r;
    end
    for (int unsigned i = 0; i < unique_count; i++) begin
      if (unique_keys[i] == key) begin
        r.entry_index = IDX_W'(i);
        return r;
      end
    end
    if (unique_count >= TABLE_DEPTH) begin
      r.table_full = 1'b1;
      return r;
    end
    unique_keys[unique_count] = key;
    r.entry_index = IDX_W'(unique_count);
    r.is_new = 1'b1;
    unique_count++;
    return r;
  endfunction

  // One word drawn mostly from float values that tend to collide: signed zeros, ones, NaN.
  function automatic logic [WORD_W-1:0] float_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(7))
      0: w = 32'h0000_0000;
      1: w = 32'h8000_0000;
      2: w = 32'h3f80_0000;
      3: w = 32'hbf80_0000;
      4: w = 32'h7fc0_0000;
      5: w = 32'h7f80_0000;
      6: w = 32'hffff_ffff;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic vertex_key_t random_key();
    vertex_key_t key;
    for (int w = 0; w < KEY_WORDS; w++) key[w*WORD_W +: WORD_W] = $urandom;
    return key;
  endfunction

  function automatic vertex_key_t float_key();
    vertex_key_t key;
    for (int w = 0; w < KEY_WORDS; w++) key[w*WORD_W +: WORD_W] = float_word();
    return key;
  endfunction

  function automatic vertex_key_t uniform_key(logic [WORD_W-1:0] word);
    return {KEY_WORDS{word}};
  endfunction

  function automatic vertex_key_t flip_one_bit(vertex_key_t key);
    return key ^ (vertex_key_t'(1) << $urandom_range(KEY_W - 1));
  endfunction

  // Prints one line per mismatch and counts all of them.
  task automatic flag_error(string what);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic set_idling(int unsigned idle_pct, int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // Present one input beat, hold it until the block takes it, then record its result.
  // Valid is left high on return so back-to-back beats never drop it in between.
  task automatic send_beat(logic kind_bit, vertex_key_t key);
    result_t expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= kind_bit;
    pos_x <= key[0*WORD_W +: WORD_W];
    pos_y <= key[1*WORD_W +: WORD_W];
    pos_z <= key[2*WORD_W +: WORD_W];
    tex_u <= key[3*WORD_W +: WORD_W];
    tex_v <= key[4*WORD_W +: WORD_W];
    norm_x <= key[5*WORD_W +: WORD_W];
    norm_y <= key[6*WORD_W +: WORD_W];
    norm_z <= key[7*WORD_W +: WORD_W];
    do @(posedge clk); while (in_stall);
    expected = lookup_or_insert(kind_bit, key);
    lookup_results = {lookup_results, expected};
  endtask

  task automatic send_vertex(vertex_key_t key);
    send_beat(KIND_VERTEX, key);
  endtask

  // The vertex words of a clear beat carry random data that the block must ignore.
  task automatic send_clear();
    send_beat(KIND_CLEAR, random_key());
  endtask

  // Edge values, signed zeros, NaN payloads, a change in each single word, and clears.
  task automatic test_directed();
    vertex_key_t base;
    base = uniform_key(32'h3f80_0000);
    send_clear();
    send_vertex(uniform_key(32'h0000_0000));
    send_vertex(uniform_key(32'hffff_ffff));
    send_vertex(uniform_key(32'h0000_0000));
    send_vertex(uniform_key(32'h8000_0000));
    send_vertex(vertex_key_t'(32'h8000_0000));
    send_vertex(uniform_key(32'h7fc0_0000));
    send_vertex(uniform_key(32'h7fc0_0000));
    send_vertex(uniform_key(32'h7fc0_0001));
    send_vertex(base);
    // Flip the sign of one word at a time; every word has to take part in the match.
    for (int w = 0; w < KEY_WORDS; w++) begin
      send_vertex(base ^ (vertex_key_t'(1) << (w * WORD_W + WORD_W - 1)));
    end
    send_vertex(base ^ (vertex_key_t'(1) << (KEY_W - 1)));
    send_vertex(uniform_key(32'hffff_ffff));
    send_beat(KIND_CLEAR, uniform_key(32'hffff_ffff));
    send_clear();
    send_vertex(uniform_key(32'hffff_ffff));
  endtask

  // Mesh-like strips: each starts from an empty table, then mixes reused vertices,
  // near misses one bit away, colliding float patterns, random vertices and stray clears.
  task automatic test_mesh(int unsigned n_items);
    int unsigned sent;
    int unsigned strip_len;
    int unsigned roll;
    vertex_key_t key;
    sent = 0;
    while (sent < n_items) begin
      send_clear();
      sent++;
      strip_len = $urandom_range(60, 8);
      for (int unsigned k = 0; k < strip_len && sent < n_items; k++) begin
        roll = $urandom_range(99);
        if (roll >= 97) begin
          send_clear();
        end else begin
          if (roll < 40 && unique_count > 0) begin
            key = unique_keys[$urandom_range(unique_count - 1)];
          end else if (roll < 55 && unique_count > 0) begin
            key = flip_one_bit(unique_keys[$urandom_range(unique_count - 1)]);
          end else if (roll < 70) begin
            key = float_key();
          end else begin
            key = random_key();
          end
          send_vertex(key);
        end
        sent++;
      end
    end
  endtask

  // Fill the table to the last entry, then probe it with hits that return their index
  // and misses that must report a full table; finally check that a clear frees it again.
  task automatic test_table_full();
    int unsigned roll;
    send_clear();
    while (unique_count < TABLE_DEPTH) send_vertex(random_key());
    send_vertex(unique_keys[TABLE_DEPTH - 1]);
    send_vertex(unique_keys[0]);
    for (int k = 0; k < FULL_PROBES; k++) begin
      roll = $urandom_range(2);
      if (roll == 0) begin
        send_vertex(random_key());
      end else if (roll == 1) begin
        send_vertex(unique_keys[$urandom_range(TABLE_DEPTH - 1)]);
      end else begin
        send_vertex(flip_one_bit(unique_keys[$urandom_range(TABLE_DEPTH - 1)]));
      end
    end
    send_clear();
    send_vertex(random_key());
  endtask

  // Result side: take each output beat, compare it with the oldest prediction, and
  // stall at random.
  initial begin
    result_t want;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (lookup_results.size() == 0) begin
          flag_error($sformatf("result beat with none pending: index %0d new %0b full %0b",
                               entry_index, is_new, table_full));
        end else begin
          want = lookup_results.pop_front();
          if (entry_index !== want.entry_index) begin
            flag_error($sformatf("entry_index got %0d want %0d", entry_index,
                                 want.entry_index));
          end
          if (is_new !== want.is_new) begin
            flag_error($sformatf("is_new got %0b want %0b", is_new, want.is_new));
          end
          if (table_full !== want.table_full) begin
            flag_error($sformatf("table_full got %0b want %0b", table_full, want.table_full));
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Guard against a hung block.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[vertex_dedup_indexer_core] ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_VERTEX;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    tex_u <= '0;
    tex_v <= '0;
    norm_x <= '0;
    norm_y <= '0;
    norm_z <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    test_directed();
    test_mesh(MESH_ITEMS);
    test_table_full();

    set_idling(57, 0);
    test_mesh(MESH_ITEMS);

    set_idling(0, 57);
    test_mesh(MESH_ITEMS);

    set_idling(38, 38);
    test_mesh(MESH_ITEMS);
    test_table_full();

    // Drain the outstanding results, then allow one worst-case scan for stray beats.
    in_valid <= 1'b0;
    while (lookup_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[vertex_dedup_indexer_core] OK");
    end else begin
      $display("[vertex_dedup_indexer_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/vdi_pkg.sv
src/vdi_ram.sv
src/vdi_scan.sv
src/vertex_dedup_indexer_core.sv
verif/vertex_dedup_indexer_core_tb.sv
